### hw/rtl/glb_container_deframer_top_defines.svh
// Assertion macros for the GLB container deframer.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef GLB_CONTAINER_DEFRAMER_TOP_DEFINES_SVH
`define GLB_CONTAINER_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define GLBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define GLBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/glbd_pkg.sv
// Shared types and constants of the GLB container deframer.
// No dependencies.
package glbd_pkg;

    localparam logic [31:0] GLB_MAGIC       = 32'h4654_6C67;
    localparam logic [31:0] CHUNK_JSON      = 32'h4E4F_534A;
    localparam logic [31:0] CHUNK_BIN       = 32'h004E_4942;
    localparam logic [31:0] GLB_VERSION     = 32'd2;
    localparam logic [31:0] HEADER_BYTES    = 32'd12;
    localparam logic [31:0] CHUNK_HDR_BYTES = 32'd8;

    localparam logic [31:0] JSON_LIMIT_RST  = 32'd67108864;
    localparam logic [31:0] BIN_LIMIT_RST   = 32'd536870912;

    // input item kinds
    localparam logic IN_START = 1'b0;
    localparam logic IN_BYTE  = 1'b1;

    // configuration register indexes
    localparam logic CFG_JSON_LIMIT = 1'b0;
    localparam logic CFG_BIN_LIMIT  = 1'b1;

    // result kinds
    localparam logic [2:0] OK_JSON_BYTE = 3'd0;
    localparam logic [2:0] OK_BIN_BYTE  = 3'd1;
    localparam logic [2:0] OK_BIN_BEGIN = 3'd2;
    localparam logic [2:0] OK_JSON_END  = 3'd3;
    localparam logic [2:0] OK_DONE      = 3'd4;
    localparam logic [2:0] OK_ERROR     = 3'd5;

    // error codes
    localparam logic [3:0] ERR_SHORT      = 4'd0;
    localparam logic [3:0] ERR_MAGIC      = 4'd1;
    localparam logic [3:0] ERR_VERSION    = 4'd2;
    localparam logic [3:0] ERR_DECL_LEN   = 4'd3;
    localparam logic [3:0] ERR_OVERRUN    = 4'd4;
    localparam logic [3:0] ERR_JSON_TWICE = 4'd5;
    localparam logic [3:0] ERR_JSON_BIG   = 4'd6;
    localparam logic [3:0] ERR_BIN_BIG    = 4'd7;
    localparam logic [3:0] ERR_NO_JSON    = 4'd8;

    // one input beat makes at most this many results
    localparam int GLBD_MAX_RES   = 3;
    localparam int RES_CNT_W      = $clog2(GLBD_MAX_RES + 1);
    localparam int GLBD_RES_DEPTH = 8;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [31:0] file_length;
    } t_item;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  body_byte;
        logic [31:0] chunk_offset;
        logic [31:0] length_value;
        logic [3:0]  error_code;
        logic        last;
    } t_result;

endpackage

### hw/rtl/glbd_in_reg.sv
// Input register of the GLB container deframer: holds one accepted beat.
// Depends on glbd_pkg.
module glbd_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  glbd_pkg::t_item i_item,
    output logic            o_in_stall,
    input  logic            i_take,
    output logic            o_valid,
    output glbd_pkg::t_item o_item
);
    import glbd_pkg::*;

    logic  r_valid;
    t_item r_item;

    // stall only while a held beat cannot move on
    assign o_in_stall = r_valid & ~i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### hw/rtl/glbd_step.sv
// Parser state and per-beat decode of the GLB container deframer.
// Header checks, chunk walk, body forwarding; depends on glbd_pkg.
module glbd_step (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic                                          i_cfg_index,
    input  logic [31:0]                                   i_cfg_data,
    input  logic                                          i_fire,
    input  glbd_pkg::t_item                               i_item,
    output logic [glbd_pkg::RES_CNT_W-1:0]                o_res_cnt,
    output glbd_pkg::t_result [glbd_pkg::GLBD_MAX_RES-1:0] o_res
);
    import glbd_pkg::*;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_HEADER   = 3'd1;
    localparam logic [2:0] PH_CHUNKHDR = 3'd2;
    localparam logic [2:0] PH_BODY     = 3'd3;
    localparam logic [2:0] PH_FINISHED = 3'd4;

    function automatic t_result mk_result(input logic [2:0] kind, input logic [7:0] b,
                                          input logic [31:0] off, input logic [31:0] len,
                                          input logic [3:0] err);
        t_result r;
        r.out_kind     = kind;
        r.body_byte    = b;
        r.chunk_offset = off;
        r.length_value = len;
        r.error_code   = err;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] lane_word(input logic [7:0] b, input logic [1:0] lane);
        return {24'd0, b} << {lane, 3'b000};
    endfunction

    logic [31:0] r_json_limit, r_bin_limit;
    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_total, n_total;
    logic [31:0] r_cl, n_cl;
    logic [1:0]  r_lane, n_lane;
    logic [31:0] r_clen, n_clen;
    logic [31:0] r_ctype, n_ctype;
    logic [31:0] r_bc, n_bc;
    logic [31:0] r_jt, n_jt;
    logic        r_json_seen, n_json_seen;

    logic [RES_CNT_W-1:0]              cnt;
    t_result [GLBD_MAX_RES-1:0]        res;
    logic                              do_next;
    logic                              err_hit;
    logic [3:0]                        err_code;
    logic [31:0]                       cl_word;
    logic                              is_json, is_bin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_json_limit <= JSON_LIMIT_RST;
            r_bin_limit  <= BIN_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_JSON_LIMIT: r_json_limit <= i_cfg_data;
                CFG_BIN_LIMIT:  r_bin_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_total     = r_total;
        n_cl        = r_cl;
        n_lane      = r_lane;
        n_clen      = r_clen;
        n_ctype     = r_ctype;
        n_bc        = r_bc;
        n_jt        = r_jt;
        n_json_seen = r_json_seen;
        cnt         = '0;
        res         = '0;
        do_next     = 1'b0;
        err_hit     = 1'b0;
        err_code    = ERR_SHORT;
        cl_word     = r_cl | lane_word(i_item.data_byte, r_lane);
        is_json     = (r_ctype == CHUNK_JSON);
        is_bin      = (r_ctype == CHUNK_BIN);

        if (i_fire) begin
            if (i_item.kind == IN_START) begin
                // a start beat restarts the parse from any phase
                n_total     = i_item.file_length;
                n_pos       = '0;
                n_cl        = '0;
                n_lane      = '0;
                n_clen      = '0;
                n_ctype     = '0;
                n_bc        = '0;
                n_jt        = '0;
                n_json_seen = 1'b0;
                n_phase     = PH_HEADER;
                if (i_item.file_length < HEADER_BYTES) begin
                    err_hit  = 1'b1;
                    err_code = ERR_SHORT;
                end
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        n_cl   = cl_word;
                        n_lane = r_lane + 2'd1;
                        n_pos  = r_pos + 32'd1;
                        if (r_lane == 2'd3) begin
                            if (n_pos == 32'd4) begin
                                if (cl_word != GLB_MAGIC) begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_MAGIC;
                                end
                                n_cl = '0;
                            end else if (n_pos == 32'd8) begin
                                if (cl_word != GLB_VERSION) begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_VERSION;
                                end
                                n_cl = '0;
                            end else if (cl_word > r_total) begin
                                err_hit  = 1'b1;
                                err_code = ERR_DECL_LEN;
                            end else begin
                                do_next = 1'b1;
                            end
                        end
                    end
                    PH_CHUNKHDR: begin
                        if (r_bc < 32'd4) begin
                            n_clen = r_clen | lane_word(i_item.data_byte, r_lane);
                        end else begin
                            n_ctype = r_ctype | lane_word(i_item.data_byte, r_lane);
                        end
                        n_lane = r_lane + 2'd1;
                        n_bc   = r_bc + 32'd1;
                        n_pos  = r_pos + 32'd1;
                        if (n_bc == CHUNK_HDR_BYTES) begin
                            if (n_clen > r_cl - n_pos) begin
                                err_hit  = 1'b1;
                                err_code = ERR_OVERRUN;
                            end else if (n_ctype == CHUNK_JSON) begin
                                if (r_json_seen) begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_JSON_TWICE;
                                end else if (n_clen > r_json_limit) begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_JSON_BIG;
                                end else begin
                                    n_json_seen = 1'b1;
                                    n_jt        = '0;
                                    if (n_clen == '0) begin
                                        res[cnt] = mk_result(OK_JSON_END, 8'd0, 32'd0, 32'd0,
                                                             4'd0);
                                        cnt      = cnt + 1'b1;
                                        do_next  = 1'b1;
                                    end else begin
                                        n_phase = PH_BODY;
                                        n_bc    = '0;
                                    end
                                end
                            end else if ((n_ctype == CHUNK_BIN) && (n_clen > r_bin_limit)) begin
                                err_hit  = 1'b1;
                                err_code = ERR_BIN_BIG;
                            end else begin
                                // unknown chunks fall through here and get skipped
                                if (n_ctype == CHUNK_BIN) begin
                                    res[cnt] = mk_result(OK_BIN_BEGIN, 8'd0, 32'd0, n_clen,
                                                         4'd0);
                                    cnt      = cnt + 1'b1;
                                end
                                if (n_clen == '0) begin
                                    do_next = 1'b1;
                                end else begin
                                    n_phase = PH_BODY;
                                    n_bc    = '0;
                                end
                            end
                        end
                    end
                    PH_BODY: begin
                        n_pos = r_pos + 32'd1;
                        n_bc  = r_bc + 32'd1;
                        if (is_json) begin
                            // trailing spaces and NULs do not count
                            if (i_item.data_byte != 8'h20 && i_item.data_byte != 8'h00) begin
                                n_jt = n_bc;
                            end
                            res[cnt] = mk_result(OK_JSON_BYTE, i_item.data_byte, r_bc, 32'd0,
                                                 4'd0);
                            cnt      = cnt + 1'b1;
                        end else if (is_bin) begin
                            res[cnt] = mk_result(OK_BIN_BYTE, i_item.data_byte, r_bc, 32'd0,
                                                 4'd0);
                            cnt      = cnt + 1'b1;
                        end
                        if (n_bc == r_clen) begin
                            if (is_json) begin
                                res[cnt] = mk_result(OK_JSON_END, 8'd0, 32'd0, n_jt, 4'd0);
                                cnt      = cnt + 1'b1;
                            end
                            do_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            // end of a chunk or of the header: is there room for another chunk header
            if (do_next) begin
                if (({1'b0, n_pos} + {1'b0, CHUNK_HDR_BYTES}) > {1'b0, n_cl}) begin
                    if (n_json_seen) begin
                        res[cnt] = mk_result(OK_DONE, 8'd0, 32'd0, 32'd0, 4'd0);
                        cnt      = cnt + 1'b1;
                        n_phase  = PH_FINISHED;
                    end else begin
                        err_hit  = 1'b1;
                        err_code = ERR_NO_JSON;
                    end
                end else begin
                    n_phase = PH_CHUNKHDR;
                    n_lane  = '0;
                    n_bc    = '0;
                    n_clen  = '0;
                    n_ctype = '0;
                end
            end

            if (err_hit) begin
                res[cnt] = mk_result(OK_ERROR, 8'd0, 32'd0, 32'd0, err_code);
                cnt      = cnt + 1'b1;
                n_phase  = PH_FINISHED;
            end

            if (cnt != '0) begin
                res[cnt - 1'b1].last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_total     <= '0;
            r_cl        <= '0;
            r_lane      <= '0;
            r_clen      <= '0;
            r_ctype     <= '0;
            r_bc        <= '0;
            r_jt        <= '0;
            r_json_seen <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_total     <= n_total;
            r_cl        <= n_cl;
            r_lane      <= n_lane;
            r_clen      <= n_clen;
            r_ctype     <= n_ctype;
            r_bc        <= n_bc;
            r_jt        <= n_jt;
            r_json_seen <= n_json_seen;
        end
    end

    assign o_res_cnt = cnt;
    assign o_res     = res;

endmodule

### hw/rtl/glbd_res_fifo.sv
// Result queue of the GLB container deframer: takes up to three results
// per cycle, hands out one per beat. Depends on glbd_pkg.
module glbd_res_fifo #(
    parameter int DEPTH = glbd_pkg::GLBD_RES_DEPTH
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic [glbd_pkg::RES_CNT_W-1:0]                i_wr_cnt,
    input  glbd_pkg::t_result [glbd_pkg::GLBD_MAX_RES-1:0] i_wr_res,
    output logic                                          o_room,
    output logic                                          o_valid,
    output glbd_pkg::t_result                             o_head,
    input  logic                                          i_pop
);
    import glbd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_P = (PW + 1)'(DEPTH);
    localparam logic [CW:0]   DEPTH_C = (CW + 1)'(DEPTH);
    localparam logic [CW:0]   MAXR_C  = (CW + 1)'(GLBD_MAX_RES);

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] ptr,
                                               input logic [PW:0] k);
        logic [PW:0] s;
        s = {1'b0, ptr} + k;
        if (s >= DEPTH_P) begin
            s = s - DEPTH_P;
        end
        return s[PW-1:0];
    endfunction

    t_result        r_mem [DEPTH];
    logic [PW-1:0]  r_rd, r_wr;
    logic [CW-1:0]  r_count;

    // room for a worst-case beat after this cycle's pop
    assign o_room  = ({1'b0, r_count} + MAXR_C) <= (DEPTH_C + {{CW{1'b0}}, i_pop});
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < GLBD_MAX_RES; k++) begin
            if (RES_CNT_W'(k) < i_wr_cnt) begin
                r_mem[wrap_add(r_wr, (PW + 1)'(k))] <= i_wr_res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= wrap_add(r_wr, (PW + 1)'(i_wr_cnt));
            if (i_pop) begin
                r_rd <= wrap_add(r_rd, (PW + 1)'(1));
            end
            r_count <= r_count + CW'(i_wr_cnt) - CW'(i_pop);
        end
    end

endmodule

### hw/rtl/glb_container_deframer_top.sv
// An accepted beat waits in the input register until the result queue has room; it is then
// decoded and its results are written into the result queue, whose head drives the outputs.
// Throughput: one input beat per cycle while the input is not stalled; results leave one per
// beat, so a beat that makes two or three results gives that many result beats. The input
// stalls while a held beat finds fewer than three free RES_DEPTH-queue slots after the pop.
// Reset (synchronous, active low) clears the queue, idles the parser, restores both limits.
`include "glb_container_deframer_top_defines.svh"

module glb_container_deframer_top #(
    parameter int RES_DEPTH = glbd_pkg::GLBD_RES_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_file_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_out_kind,
    output logic [7:0]  o_body_byte,
    output logic [31:0] o_chunk_offset,
    output logic [31:0] o_length_value,
    output logic [3:0]  o_error_code,
    output logic        o_last
);
    import glbd_pkg::*;

    t_item                       w_in_item;
    t_item                       w_item;
    logic                        w_item_valid;
    logic                        w_room;
    logic                        w_fire;
    logic                        w_pop;
    logic [RES_CNT_W-1:0]        w_res_cnt;
    t_result [GLBD_MAX_RES-1:0]  w_res;
    t_result                     w_head;
    logic                        w_end_res;
    logic                        w_byte_res;
    logic                        w_byte_clean;

    assign w_in_item.kind        = i_kind;
    assign w_in_item.data_byte   = i_data_byte;
    assign w_in_item.file_length = i_file_length;

    glbd_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (w_in_item),
        .o_in_stall (o_in_stall),
        .i_take     (w_room),
        .o_valid    (w_item_valid),
        .o_item     (w_item)
    );

    assign w_fire = w_item_valid & w_room;

    glbd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_res_cnt   (w_res_cnt),
        .o_res       (w_res)
    );

    assign w_pop = o_out_valid & ~i_out_stall;

    glbd_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_cnt (w_res_cnt),
        .i_wr_res (w_res),
        .o_room   (w_room),
        .o_valid  (o_out_valid),
        .o_head   (w_head),
        .i_pop    (w_pop)
    );

    assign o_out_kind     = w_head.out_kind;
    assign o_body_byte    = w_head.body_byte;
    assign o_chunk_offset = w_head.chunk_offset;
    assign o_length_value = w_head.length_value;
    assign o_error_code   = w_head.error_code;
    assign o_last         = w_head.last;

    assign w_end_res    = o_out_valid & ((o_out_kind == OK_ERROR) | (o_out_kind == OK_DONE));
    assign w_byte_res   = o_out_valid &
                          ((o_out_kind == OK_JSON_BYTE) | (o_out_kind == OK_BIN_BYTE));
    assign w_byte_clean = (o_length_value == '0) && (o_error_code == '0);

    // done and error always close the results of their beat
    `GLBD_ASSERT_IMP(a_end_is_last, w_end_res, o_last, "done or error result without last")
    `GLBD_ASSERT_IMP(a_byte_fields, w_byte_res, w_byte_clean, "body byte with length or error")
    `GLBD_ASSERT_NXT(a_res_queued, w_fire && (w_res_cnt != '0), o_out_valid, "results lost")

endmodule

### tb/sv/glbd_deframe_checker.sv
// Result checker for the GLB container deframer: predicts the result beats of every
// accepted input beat and compares them with what leaves the block, in order.
// Depends on glbd_pkg for the item, result, kind and error definitions.
module glbd_deframe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_file_length,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_out_kind,
    input  logic [7:0]  i_body_byte,
    input  logic [31:0] i_chunk_offset,
    input  logic [31:0] i_length_value,
    input  logic [3:0]  i_error_code,
    input  logic        i_last,
    output int          o_mismatch_count,
    output int          o_results_owed
);
    import glbd_pkg::*;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_HEADER,
        PARSE_CHUNK_HDR,
        PARSE_BODY,
        PARSE_DONE
    } parse_phase_e;

    parse_phase_e phase;
    logic [31:0]  file_pos;
    logic [31:0]  file_total;
    logic [31:0]  decl_len;
    logic [31:0]  byte_shift;
    logic [31:0]  chunk_len;
    logic [31:0]  chunk_type;
    logic [31:0]  body_cnt;
    logic [31:0]  json_trim_len;
    logic         json_seen;
    logic [31:0]  json_limit;
    logic [31:0]  bin_limit;
    t_result      owed_q[$];

    task automatic push_result(input logic [2:0] kind, input logic [7:0] b,
                               input logic [31:0] off, input logic [31:0] len,
                               input logic [3:0] err);
        t_result r;
        r.out_kind     = kind;
        r.body_byte    = b;
        r.chunk_offset = off;
        r.length_value = len;
        r.error_code   = err;
        r.last         = 1'b0;
        owed_q.push_back(r);
    endtask

    task automatic abort_parse(input logic [3:0] err);
        push_result(OK_ERROR, 8'd0, 32'd0, 32'd0, err);
        phase = PARSE_DONE;
    endtask

    // walk ends once fewer than a chunk header's worth of declared bytes remain
    task automatic walk_next_chunk();
        if ({1'b0, file_pos} + {1'b0, CHUNK_HDR_BYTES} > {1'b0, decl_len}) begin
            if (json_seen) begin
                push_result(OK_DONE, 8'd0, 32'd0, 32'd0, 4'd0);
                phase = PARSE_DONE;
            end else begin
                abort_parse(ERR_NO_JSON);
            end
        end else begin
            phase      = PARSE_CHUNK_HDR;
            byte_shift = '0;
            body_cnt   = '0;
            chunk_len  = '0;
            chunk_type = '0;
        end
    endtask

    task automatic close_chunk_header();
        if (chunk_len > decl_len - file_pos) begin
            abort_parse(ERR_OVERRUN);
        end else if (chunk_type == CHUNK_JSON && json_seen) begin
            abort_parse(ERR_JSON_TWICE);
        end else if (chunk_type == CHUNK_JSON && chunk_len > json_limit) begin
            abort_parse(ERR_JSON_BIG);
        end else if (chunk_type == CHUNK_BIN && chunk_len > bin_limit) begin
            abort_parse(ERR_BIN_BIG);
        end else begin
            if (chunk_type == CHUNK_JSON) begin
                json_seen     = 1'b1;
                json_trim_len = '0;
                if (chunk_len == 0)
                    push_result(OK_JSON_END, 8'd0, 32'd0, 32'd0, 4'd0);
            end else if (chunk_type == CHUNK_BIN) begin
                push_result(OK_BIN_BEGIN, 8'd0, 32'd0, chunk_len, 4'd0);
            end
            if (chunk_len == 0) begin
                walk_next_chunk();
            end else begin
                phase    = PARSE_BODY;
                body_cnt = '0;
            end
        end
    endtask

    task automatic predict_beat(input t_item beat);
        int          first;
        logic [31:0] b32;
        logic [31:0] off;
        first = owed_q.size();
        b32   = {24'd0, beat.data_byte};
        if (beat.kind == IN_START) begin
            // a start beat restarts the parse from any state
            file_total    = beat.file_length;
            file_pos      = '0;
            decl_len      = '0;
            byte_shift    = '0;
            chunk_len     = '0;
            chunk_type    = '0;
            body_cnt      = '0;
            json_trim_len = '0;
            json_seen     = 1'b0;
            phase         = PARSE_HEADER;
            if (file_total < HEADER_BYTES)
                abort_parse(ERR_SHORT);
        end else begin
            case (phase)
                PARSE_HEADER: begin
                    decl_len   = decl_len | (b32 << byte_shift);
                    byte_shift = byte_shift + 32'd8;
                    file_pos   = file_pos + 32'd1;
                    if (byte_shift == 32'd32) begin
                        byte_shift = '0;
                        if (file_pos == 32'd4) begin
                            if (decl_len != GLB_MAGIC)
                                abort_parse(ERR_MAGIC);
                            decl_len = '0;
                        end else if (file_pos == 32'd8) begin
                            if (decl_len != GLB_VERSION)
                                abort_parse(ERR_VERSION);
                            decl_len = '0;
                        end else if (decl_len > file_total) begin
                            abort_parse(ERR_DECL_LEN);
                        end else begin
                            walk_next_chunk();
                        end
                    end
                end
                PARSE_CHUNK_HDR: begin
                    if (body_cnt < 32'd4)
                        chunk_len = chunk_len | (b32 << byte_shift);
                    else
                        chunk_type = chunk_type | (b32 << byte_shift);
                    byte_shift = (byte_shift + 32'd8) & 32'd31;
                    body_cnt   = body_cnt + 32'd1;
                    file_pos   = file_pos + 32'd1;
                    if (body_cnt == CHUNK_HDR_BYTES)
                        close_chunk_header();
                end
                PARSE_BODY: begin
                    off      = body_cnt;
                    file_pos = file_pos + 32'd1;
                    body_cnt = body_cnt + 32'd1;
                    if (chunk_type == CHUNK_JSON) begin
                        if (beat.data_byte != 8'h20 && beat.data_byte != 8'h00)
                            json_trim_len = body_cnt;
                        push_result(OK_JSON_BYTE, beat.data_byte, off, 32'd0, 4'd0);
                    end else if (chunk_type == CHUNK_BIN) begin
                        push_result(OK_BIN_BYTE, beat.data_byte, off, 32'd0, 4'd0);
                    end
                    if (body_cnt == chunk_len) begin
                        if (chunk_type == CHUNK_JSON)
                            push_result(OK_JSON_END, 8'd0, 32'd0, json_trim_len, 4'd0);
                        walk_next_chunk();
                    end
                end
                default: ;  // idle or finished: byte dropped
            endcase
        end
        // mark the newest result of this beat as its last
        if (owed_q.size() > first)
            owed_q[owed_q.size() - 1].last = 1'b1;
    endtask

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        o_mismatch_count++;
        if (o_mismatch_count <= 10)
            $display({"%0t %s: exp kind=%0d byte=%02h off=%0d len=%0d err=%0d last=%0b,",
                      " got kind=%0d byte=%02h off=%0d len=%0d err=%0d last=%0b"},
                     $time, what, want.out_kind, want.body_byte, want.chunk_offset,
                     want.length_value, want.error_code, want.last, got.out_kind,
                     got.body_byte, got.chunk_offset, got.length_value, got.error_code,
                     got.last);
    endtask

    always @(posedge i_clk) begin : watch
        t_item   beat;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            phase         = PARSE_IDLE;
            file_pos      = '0;
            file_total    = '0;
            decl_len      = '0;
            byte_shift    = '0;
            chunk_len     = '0;
            chunk_type    = '0;
            body_cnt      = '0;
            json_trim_len = '0;
            json_seen     = 1'b0;
            json_limit    = JSON_LIMIT_RST;
            bin_limit     = BIN_LIMIT_RST;
            owed_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_JSON_LIMIT)
                    json_limit = i_cfg_data;
                else
                    bin_limit = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                beat.kind        = i_kind;
                beat.data_byte   = i_data_byte;
                beat.file_length = i_file_length;
                predict_beat(beat);
            end
            if (i_out_valid && !i_out_stall) begin
                got.out_kind     = i_out_kind;
                got.body_byte    = i_body_byte;
                got.chunk_offset = i_chunk_offset;
                got.length_value = i_length_value;
                got.error_code   = i_error_code;
                got.last         = i_last;
                if (owed_q.size() == 0) begin
                    want = '0;
                    note_mismatch("result with nothing owed", want, got);
                end else begin
                    want = owed_q.pop_front();
                    if (got !== want)
                        note_mismatch("result mismatch", want, got);
                end
            end
        end
        o_results_owed = owed_q.size();
    end

endmodule

### tb/sv/tb_glb_container_deframer_top.sv
// Testbench top for glb_container_deframer_top: builds GLB byte streams (good, broken and
// truncated), drives them with random gaps and output stalls under several size limits.
// Depends on glbd_pkg, glbd_deframe_checker and the deframer RTL.
module tb_glb_container_deframer_top;
    import glbd_pkg::*;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic        cfg_index   = 1'b0;
    logic [31:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        kind        = 1'b0;
    logic [7:0]  data_byte   = '0;
    logic [31:0] file_length = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [2:0]  out_kind;
    logic [7:0]  body_byte;
    logic [31:0] chunk_offset;
    logic [31:0] length_value;
    logic [3:0]  error_code;
    logic        last;
    int          mismatches;
    int          owed;

    t_item       beat_q[$];
    logic [7:0]  file_q[$];
    bit          quiet        = 1'b0;
    bit          hold_off_req = 1'b0;
    int          stall_left   = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    glb_container_deframer_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind),
        .i_data_byte    (data_byte),
        .i_file_length  (file_length),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_kind     (out_kind),
        .o_body_byte    (body_byte),
        .o_chunk_offset (chunk_offset),
        .o_length_value (length_value),
        .o_error_code   (error_code),
        .o_last         (last)
    );

    glbd_deframe_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_kind           (kind),
        .i_data_byte      (data_byte),
        .i_file_length    (file_length),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_kind       (out_kind),
        .i_body_byte      (body_byte),
        .i_chunk_offset   (chunk_offset),
        .i_length_value   (length_value),
        .i_error_code     (error_code),
        .i_last           (last),
        .o_mismatch_count (mismatches),
        .o_results_owed   (owed)
    );

    task automatic queue_start(input logic [31:0] len);
        t_item it;
        it.kind        = IN_START;
        it.data_byte   = 8'($urandom);
        it.file_length = len;
        beat_q.push_back(it);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        t_item it;
        it.kind        = IN_BYTE;
        it.data_byte   = b;
        it.file_length = $urandom;
        beat_q.push_back(it);
    endtask

    task automatic file_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_q.push_back(w[8*i +: 8]);
    endtask

    task automatic queue_file(input int cut);
        for (int i = 0; i < cut && i < file_q.size(); i++)
            queue_byte(file_q[i]);
    endtask

    // one container, mostly well formed; some get a header fault, an overrun, a cut or a short length
    task automatic add_glb_file();
        int          n_chunks;
        int          fault;
        int          trail;
        int          cut;
        logic [31:0] clen [3];
        logic [31:0] ctype [3];
        logic [31:0] decl;
        logic [31:0] decl_field;
        logic [31:0] flen;
        logic [31:0] len_field;
        logic [31:0] ver;
        logic [7:0]  b;
        n_chunks = $urandom_range(0, 3);
        fault    = $urandom_range(0, 15);
        decl     = HEADER_BYTES;
        for (int i = 0; i < n_chunks; i++) begin
            if (i == 0) begin
                ctype[i] = ($urandom_range(0, 3) != 0) ? CHUNK_JSON : CHUNK_BIN;
            end else begin
                case ($urandom_range(0, 9))
                    0:       ctype[i] = CHUNK_JSON;
                    7, 8, 9: ctype[i] = $urandom;
                    default: ctype[i] = CHUNK_BIN;
                endcase
            end
            clen[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                  : $urandom_range(0, 10);
            decl = decl + CHUNK_HDR_BYTES + clen[i];
        end
        if ($urandom_range(0, 2) == 0)
            decl = decl + $urandom_range(1, 7);
        case ($urandom_range(0, 5))
            0: flen = 32'hFFFF_FFFF;
            1: flen = decl + $urandom_range(1, 64);
            2: begin
                flen = $urandom;
                if (flen < decl)
                    flen = decl;
            end
            default: flen = decl;
        endcase
        decl_field = decl;
        if (fault == 2) begin
            if (flen == 32'hFFFF_FFFF)
                flen = decl;
            decl_field = flen + $urandom_range(1, 100);
        end
        if (fault == 5) begin
            queue_start($urandom_range(0, 11));
            if ($urandom_range(0, 1) == 0)
                queue_byte(8'($urandom));
            return;
        end
        file_q.delete();
        file_word(fault == 0 ? GLB_MAGIC ^ (32'd1 << $urandom_range(0, 31)) : GLB_MAGIC);
        ver = GLB_VERSION;
        if (fault == 1)
            ver = ($urandom_range(0, 1) == 0) ? 32'd1
                                              : GLB_VERSION ^ (32'd1 << $urandom_range(0, 31));
        file_word(ver);
        file_word(decl_field);
        for (int i = 0; i < n_chunks; i++) begin
            len_field = clen[i];
            if (fault == 3 && i == n_chunks - 1) begin
                // just past what the declared length leaves after this chunk header
                len_field = decl - file_q.size() - CHUNK_HDR_BYTES + $urandom_range(1, 50);
                if ($urandom_range(0, 3) == 0)
                    len_field = 32'hFFFF_FFFF;
            end
            file_word(len_field);
            file_word(ctype[i]);
            trail = $urandom_range(0, 3);
            for (int j = 0; j < clen[i]; j++) begin
                b = 8'($urandom);
                if (ctype[i] == CHUNK_JSON && j + trail >= clen[i])
                    b = ($urandom_range(0, 1) == 0) ? 8'h20 : 8'h00;
                file_q.push_back(b);
            end
        end
        while (file_q.size() < decl)
            file_q.push_back(8'($urandom));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom));
        cut = (fault == 4) ? $urandom_range(1, file_q.size() - 1) : file_q.size();
        queue_start(flen);
        queue_file(cut);
    endtask

    // called and returns at a falling edge
    task automatic send_beats();
        t_item it;
        while (beat_q.size() > 0) begin
            it = beat_q.pop_front();
            if (!quiet && $urandom_range(0, 5) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            in_valid    <= 1'b1;
            kind        <= it.kind;
            data_byte   <= it.data_byte;
            file_length <= it.file_length;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            @(negedge clk);
        end
        in_valid <= 1'b0;
    endtask

    task automatic run_random(input int n);
        while (beat_q.size() < n)
            add_glb_file();
        send_beats();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        wait (owed == 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // receiver side: random stall bursts, one long hold-off on request
    always @(negedge clk) begin
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = 400;
        end else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 13);
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin
        #6_000_000;
        $display("tb_glb_container_deframer_top failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // short files, a beat after an error, restart mid-header, an empty JSON chunk
        // that ends the container, then a beat past the declared length
        queue_start(32'd0);
        queue_byte(8'hA5);
        queue_start(32'd11);
        queue_start(32'hFFFF_FFFF);
        queue_byte(8'h67);
        queue_byte(8'h6C);
        file_q.delete();
        file_word(GLB_MAGIC);
        file_word(GLB_VERSION);
        file_word(32'd20);
        file_word(32'd0);
        file_word(CHUNK_JSON);
        queue_start(32'd20);
        queue_file(file_q.size());
        queue_byte(8'hFF);
        send_beats();
        run_random(80);

        wait_drained();
        write_cfg(CFG_JSON_LIMIT, 32'hFFFF_FFFF);
        write_cfg(CFG_BIN_LIMIT, 32'hFFFF_FFFF);
        hold_off_req = 1'b1;
        run_random(80);

        wait_drained();
        write_cfg(CFG_JSON_LIMIT, 32'd0);
        write_cfg(CFG_BIN_LIMIT, 32'd0);
        run_random(60);

        wait_drained();
        write_cfg(CFG_JSON_LIMIT, $urandom_range(0, 12));
        write_cfg(CFG_BIN_LIMIT, $urandom_range(0, 12));
        run_random(80);

        wait_drained();
        write_cfg(CFG_JSON_LIMIT, JSON_LIMIT_RST);
        write_cfg(CFG_BIN_LIMIT, $urandom_range(0, 40));
        quiet = 1'b1;
        run_random(80);

        wait_drained();
        if (mismatches == 0)
            $display("tb_glb_container_deframer_top passed");
        else
            $display("tb_glb_container_deframer_top failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/glbd_pkg.sv
hw/rtl/glbd_in_reg.sv
hw/rtl/glbd_step.sv
hw/rtl/glbd_res_fifo.sv
hw/rtl/glb_container_deframer_top.sv
tb/sv/glbd_deframe_checker.sv
tb/sv/tb_glb_container_deframer_top.sv
